### hdl/pscl_pkg.sv
// Shared constants, key codes, result codes and types for the keypad code lock.
`default_nettype none

package pscl_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0]       digit_t;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_DIGITS);

  localparam logic [7:0] KEY_DELETE   = 8'd42;
  localparam logic [7:0] KEY_CONFIRM  = 8'd10;
  localparam logic [7:0] KEY_DIGIT_LO = 8'd48;
  localparam logic [7:0] KEY_DIGIT_HI = 8'd57;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_MASK  = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_e;

  typedef enum logic [2:0] {
    OUT_PENDING    = 3'd0,
    OUT_EMPTY      = 3'd1,
    OUT_GO_CONFIRM = 3'd2,
    OUT_GRANTED    = 3'd3,
    OUT_DENIED     = 3'd4
  } outcome_e;

  typedef struct packed {
    echo_e      echo;
    logic [3:0] cursor;
    outcome_e   outcome;
    logic       in_confirm;
  } result_t;

endpackage

`default_nettype wire

### hdl/pscl_core.sv
// Entry state of the code lock: digit stores, counts, phase and per-key decision logic.
`default_nettype none

module pscl_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       key_i,
  output pscl_pkg::result_t result_o
);
  import pscl_pkg::*;

  logic   phase_q, phase_d;
  cnt_t   first_cnt_q, first_cnt_d;
  cnt_t   second_cnt_q, second_cnt_d;
  digit_t first_dig_q  [MAX_DIGITS];
  digit_t second_dig_q [MAX_DIGITS];
  digit_t second_next  [MAX_DIGITS];

  logic       is_confirm, is_backspace, is_digit;
  cnt_t       cnt, new_cnt;
  logic       dig_wr, entry_end, mismatch, entries_match;
  idx_t       wr_idx;
  logic [7:0] key_off;
  digit_t     dig_val;
  echo_e      echo;
  outcome_e   outcome;

  assign is_confirm   = (key_i == KEY_CONFIRM);
  assign is_backspace = (key_i == KEY_DELETE);
  assign is_digit     = (key_i >= KEY_DIGIT_LO) && (key_i <= KEY_DIGIT_HI);
  assign key_off      = key_i - KEY_DIGIT_LO;
  assign dig_val      = key_off[3:0];
  assign cnt          = phase_q ? second_cnt_q : first_cnt_q;
  assign wr_idx       = idx_t'(cnt);

  always_comb begin
    new_cnt   = cnt;
    echo      = ECHO_NONE;
    dig_wr    = 1'b0;
    entry_end = 1'b0;
    if (is_confirm) begin
      entry_end = 1'b1;
    end else if (is_backspace) begin
      if (cnt != '0) begin
        new_cnt = cnt - cnt_t'(1);
        echo    = ECHO_ERASE;
      end
    end else if (is_digit) begin
      if (cnt < MAX_CNT) begin
        dig_wr  = 1'b1;
        new_cnt = cnt + cnt_t'(1);
        echo    = ECHO_MASK;
      end
      if (new_cnt >= MAX_CNT) begin
        entry_end = 1'b1;
      end
    end
  end

  // The confirming entry is compared including a digit written by this key.
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      second_next[i] = (dig_wr && phase_q && wr_idx == idx_t'(i)) ? dig_val : second_dig_q[i];
      if (cnt_t'(i) < new_cnt && first_dig_q[i] != second_next[i]) begin
        mismatch = 1'b1;
      end
    end
    entries_match = !mismatch && (first_cnt_q == new_cnt);
  end

  always_comb begin
    phase_d      = phase_q;
    first_cnt_d  = phase_q ? first_cnt_q : new_cnt;
    second_cnt_d = phase_q ? new_cnt : second_cnt_q;
    outcome      = OUT_PENDING;
    if (entry_end) begin
      if (!phase_q) begin
        if (new_cnt == '0) begin
          outcome = OUT_EMPTY;
        end else begin
          outcome      = OUT_GO_CONFIRM;
          phase_d      = 1'b1;
          second_cnt_d = '0;
        end
      end else begin
        outcome      = entries_match ? OUT_GRANTED : OUT_DENIED;
        phase_d      = 1'b0;
        first_cnt_d  = '0;
        second_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && dig_wr) begin
      if (phase_q) begin
        second_dig_q[wr_idx] <= dig_val;
      end else begin
        first_dig_q[wr_idx] <= dig_val;
      end
    end
  end

  assign result_o.echo       = echo;
  assign result_o.cursor     = 4'(phase_d ? second_cnt_d : first_cnt_d);
  assign result_o.outcome    = outcome;
  assign result_o.in_confirm = phase_d;

endmodule

`default_nettype wire

### hdl/pin_set_confirm_lock.sv
// Top level of the keypad code lock with request input and result output registers.
`default_nettype none

// Keypad code lock: each request carries one ASCII key and yields exactly one
// result. A code is entered and then entered again to confirm it; the result
// reports the mask echo, the cursor column, the outcome and the phase. The key
// of a request is captured in the input register at the edge that accepts it,
// and its result is written to the result register when it advances out of the
// input register; one request is accepted in every cycle unless the input side
// stalls. The per-key update of the entry counts and the eight-digit compare sit
// in the single stage between those registers. The result register is held
// while out_stall_i is high, and the input side stalls only when both registers
// are full and the output is stalled.
module pin_set_confirm_lock (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] echo_action_o,
  output logic [3:0] cursor_pos_o,
  output logic [2:0] outcome_o,
  output logic       in_confirm_o
);
  import pscl_pkg::*;

  logic       in_valid_q;
  logic [7:0] key_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res;
  logic       advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_q <= key_code_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  pscl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .key_i    (key_q),
    .result_o (res)
  );

  assign out_valid_o   = out_valid_q;
  assign echo_action_o = res_q.echo;
  assign cursor_pos_o  = res_q.cursor;
  assign outcome_o     = res_q.outcome;
  assign in_confirm_o  = res_q.in_confirm;

endmodule

`default_nettype wire

### hdl/pscl_checker.sv
// Port-level assertions for the keypad code lock and their binding to the top level.
`default_nettype none

module pscl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] echo_action_o,
  input logic [3:0] cursor_pos_o,
  input logic [2:0] outcome_o,
  input logic       in_confirm_o
);
  import pscl_pkg::*;

  // A stalled result stays valid with its outcome and cursor unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o) && $stable(cursor_pos_o))
    else $error("Stalled result changed.");

  // A finished entry always leaves a fresh, empty entry behind.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != OUT_PENDING |-> cursor_pos_o == 4'd0)
    else $error("Cursor not reset after an entry ended.");

  // The phase reported must follow the outcome.
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_GRANTED || outcome_o == OUT_DENIED
                    || outcome_o == OUT_EMPTY) |-> !in_confirm_o)
    else $error("Phase does not match the outcome.");

  a_go_confirm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_GO_CONFIRM |-> in_confirm_o)
    else $error("Confirm phase not entered.");

  // A masked digit that does not end the entry advances the cursor.
  a_mask_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && echo_action_o == ECHO_MASK && outcome_o == OUT_PENDING
      |-> cursor_pos_o != 4'd0)
    else $error("Echoed digit left the cursor at zero.");

endmodule

bind pin_set_confirm_lock pscl_checker u_pscl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .echo_action_o (echo_action_o),
  .cursor_pos_o  (cursor_pos_o),
  .outcome_o     (outcome_o),
  .in_confirm_o  (in_confirm_o)
);

`default_nettype wire

### tb/sv/lock_result_checker.sv
// Checker that predicts and compares every result of the keypad code lock.
module lock_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] key_code_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] echo_action_i,
  input  logic [3:0] cursor_pos_i,
  input  logic [2:0] outcome_i,
  input  logic       in_confirm_i,
  output int         errors_o,
  output int         pending_o
);
  import pscl_pkg::*;

  logic    confirming;
  digit_t  code_digits [MAX_DIGITS];
  int      code_len;
  digit_t  repeat_digits [MAX_DIGITS];
  int      repeat_len;
  result_t lock_results [$];

  function automatic result_t lock_key(input logic [7:0] key);
    result_t res;
    logic    finish;
    logic    same;
    int      len;
    res.echo    = ECHO_NONE;
    res.outcome = OUT_PENDING;
    finish      = 1'b0;
    len         = confirming ? repeat_len : code_len;
    if (key == KEY_CONFIRM) begin
      finish = 1'b1;
    end else if (key == KEY_DELETE) begin
      if (len > 0) begin
        len--;
        res.echo = ECHO_ERASE;
      end
    end else if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
      if (len < MAX_DIGITS) begin
        if (confirming) begin
          repeat_digits[len] = digit_t'(key - KEY_DIGIT_LO);
        end else begin
          code_digits[len] = digit_t'(key - KEY_DIGIT_LO);
        end
        len++;
        res.echo = ECHO_MASK;
      end
      if (len >= MAX_DIGITS) finish = 1'b1;
    end
    if (confirming) begin
      repeat_len = len;
    end else begin
      code_len = len;
    end
    if (finish) begin
      if (!confirming) begin
        if (code_len == 0) begin
          res.outcome = OUT_EMPTY;
        end else begin
          res.outcome = OUT_GO_CONFIRM;
          confirming  = 1'b1;
          repeat_len  = 0;
        end
      end else begin
        same = (code_len == repeat_len);
        for (int i = 0; i < code_len; i++) begin
          if (same && code_digits[i] != repeat_digits[i]) same = 1'b0;
        end
        res.outcome = same ? OUT_GRANTED : OUT_DENIED;
        confirming  = 1'b0;
        code_len    = 0;
        repeat_len  = 0;
      end
    end
    res.cursor     = 4'(confirming ? repeat_len : code_len);
    res.in_confirm = confirming;
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] seen);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      confirming = 1'b0;
      code_len   = 0;
      repeat_len = 0;
      lock_results.delete();
      errors_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (lock_results.size() == 0) begin
          $display("%0t: result with no request waiting, actual echo %0d cursor %0d outcome %0d",
                   $time, echo_action_i, cursor_pos_i, outcome_i);
          errors_o++;
        end else begin
          want = lock_results.pop_front();
          if (echo_action_i !== want.echo) flag_field("echo_action", want.echo, echo_action_i);
          if (cursor_pos_i !== want.cursor) flag_field("cursor_pos", want.cursor, cursor_pos_i);
          if (outcome_i !== want.outcome) flag_field("outcome", want.outcome, outcome_i);
          if (in_confirm_i !== want.in_confirm) begin
            flag_field("in_confirm", want.in_confirm, in_confirm_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) lock_results.push_back(lock_key(key_code_i));
    end
    pending_o = lock_results.size();
  end

endmodule

### tb/sv/pin_set_confirm_lock_test.sv
// Top of the keypad code lock testbench: clock, reset, key stimulus and the verdict.
module pin_set_confirm_lock_test;
  import pscl_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] key_code = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] echo_action;
  logic [3:0] cursor_pos;
  logic [2:0] outcome;
  logic       in_confirm;
  int         errors;
  int         pending;

  int   send_idle_pct = 17;
  int   recv_idle_pct = 73;
  int   keys_sent = 0;
  logic hold_req = 1'b0;

  logic [7:0] warmup_keys [23] = '{
    8'd0, 8'd255, KEY_DELETE, KEY_CONFIRM,
    KEY_DIGIT_LO, KEY_DIGIT_HI, KEY_DELETE, 8'(KEY_DIGIT_LO + 1), KEY_CONFIRM,
    KEY_DIGIT_LO, 8'(KEY_DIGIT_LO + 1), KEY_CONFIRM,
    KEY_DIGIT_HI, 8'(KEY_DIGIT_HI - 1), 8'(KEY_DIGIT_HI - 2), 8'(KEY_DIGIT_HI - 3),
    8'(KEY_DIGIT_HI - 4), 8'(KEY_DIGIT_HI - 5), 8'(KEY_DIGIT_HI - 6), 8'(KEY_DIGIT_HI - 7),
    KEY_CONFIRM, 8'(KEY_DIGIT_LO - 1), 8'(KEY_DIGIT_HI + 1)
  };

  pin_set_confirm_lock dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .key_code_i   (key_code),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .echo_action_o(echo_action),
    .cursor_pos_o (cursor_pos),
    .outcome_o    (outcome),
    .in_confirm_o (in_confirm)
  );

  lock_result_checker checker_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .key_code_i   (key_code),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .echo_action_i(echo_action),
    .cursor_pos_i (cursor_pos),
    .outcome_i    (outcome),
    .in_confirm_i (in_confirm),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_key(input logic [7:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_code <= key;
    do @(posedge clk); while (in_stall);
    keys_sent++;
  endtask

  function automatic logic [7:0] stray_key();
    logic [7:0] key;
    do key = 8'($urandom_range(255));
    while (key == KEY_CONFIRM || key == KEY_DELETE ||
           (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI));
    return key;
  endfunction

  // An entry is typed with occasional stray keys and corrected typos; a full
  // entry ends by itself, a shorter one ends on the confirm key.
  task automatic send_entry(input int digits [$]);
    foreach (digits[i]) begin
      if ($urandom_range(99) < 8) send_key(stray_key());
      if (i < MAX_DIGITS - 1 && $urandom_range(99) < 8) begin
        send_key(8'(KEY_DIGIT_LO + $urandom_range(9)));
        send_key(KEY_DELETE);
      end
      send_key(8'(KEY_DIGIT_LO + digits[i]));
    end
    if (digits.size() < MAX_DIGITS) send_key(KEY_CONFIRM);
  endtask

  task automatic run_traffic(input int count);
    int goal;
    int code [$];
    int again [$];
    int len;
    goal = keys_sent + count;
    while (keys_sent < goal) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 4)) send_key(8'($urandom_range(255)));
      end else begin
        code.delete();
        len = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, MAX_DIGITS);
        repeat (len) code.push_back($urandom_range(9));
        send_entry(code);
        if (len > 0) begin
          again = code;
          case ($urandom_range(9))
            0: again[$urandom_range(len - 1)] = $urandom_range(9);
            1: void'(again.pop_back());
            2: if (len < MAX_DIGITS) again.push_back($urandom_range(9));
            3: again.delete();
            default: ;
          endcase
          send_entry(again);
        end
      end
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (warmup_keys[i]) send_key(warmup_keys[i]);
    run_traffic(630);
    send_idle_pct = 73;
    recv_idle_pct = 17;
    run_traffic(630);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_traffic(40);
    run_traffic(600);
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hdl/pscl_pkg.sv
hdl/pscl_core.sv
hdl/pin_set_confirm_lock.sv
hdl/pscl_checker.sv
tb/sv/lock_result_checker.sv
tb/sv/pin_set_confirm_lock_test.sv
